### rtl/ple_pkg.sv
// shared constants, codes and types of the positional list engine
package ple_pkg;

	// list depth and field widths
	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int CNT_W    = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// what one cell does with its entry in a cycle
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LOAD  = 2'd1,
		SEL_LEFT  = 2'd2,
		SEL_RIGHT = 2'd3
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t           sel;
		logic [VALUE_W-1:0]  value;
	} ple_cell_ctl_t;

endpackage

### rtl/ple_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares with the key
module ple_cell import ple_pkg::*; (
	input  logic                clk,
	input  ple_cell_ctl_t       ctl,
	input  logic [VALUE_W-1:0]  left_data,
	input  logic [VALUE_W-1:0]  right_data,
	output logic [VALUE_W-1:0]  data,
	output logic                match
);

	logic [VALUE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.sel)
			SEL_HOLD:  data_q <= data_q;
			SEL_LOAD:  data_q <= ctl.value;
			SEL_LEFT:  data_q <= left_data;
			SEL_RIGHT: data_q <= right_data;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == ctl.value);

endmodule

### rtl/ple_prio.sv
// first-set priority encoder over the cell match vector
module ple_prio import ple_pkg::*; (
	input  logic [CAPACITY-1:0]  req,
	output logic                 found,
	output logic [CNT_W-1:0]     idx
);

	logic [CAPACITY-1:0] first;

	// isolate the lowest set bit
	assign first = req & (~req + CAPACITY'(1));
	assign found = |req;

	always_comb begin
		idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				idx = idx | CNT_W'(i);
			end
		end
	end

endmodule

### rtl/positional_list_engine.sv
// top level of the positional list engine: control, cell chain and result register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  request | cmd_valid | cmd_stall | command, at_end, position, value
//  result  | rsp_valid | rsp_stall | status, result_index, entry_count
//
// a request is registered in the request stage, in which every cell shifts or
// compares in parallel; the encode stage then finds the first match and loads the
// result register, which a result stall can hold off; a new request is taken only
// once the previous one has left the encode stage
// reset clears the entry count and all valid flags; cell contents are not reset
// a stalled result waits in the output register while the next request runs
module positional_list_engine import ple_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [1:0]          command,
	input  logic                at_end,
	input  logic [CNT_W-1:0]    position,
	input  logic [VALUE_W-1:0]  value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          status,
	output logic [CNT_W-1:0]    result_index,
	output logic [CNT_W-1:0]    entry_count
);

	// request stage
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic                at_end_s1;
	logic [CNT_W-1:0]    pos_s1;
	logic [VALUE_W-1:0]  value_s1;

	// encode stage
	logic                valid_s2;
	status_t             status_s2;
	logic [CNT_W-1:0]    index_s2;
	logic                search_s2;
	logic [CAPACITY-1:0] match_s2;

	// list occupancy
	logic [CNT_W-1:0]    count_q;

	// result register
	logic                out_valid_q;
	status_t             status_q;
	logic [CNT_W-1:0]    index_q;
	logic [CNT_W-1:0]    count_out_q;

	logic                accept;
	logic                s2_go;

	// one request in flight at a time
	assign cmd_stall = valid_s1 | valid_s2;
	assign accept    = cmd_valid & ~cmd_stall;
	assign s2_go     = valid_s2 & (~out_valid_q | ~rsp_stall);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_t'(command);
			at_end_s1 <= at_end;
			pos_s1    <= position;
			value_s1  <= value;
		end
	end

	// decode of the current request against the count before the step
	logic [CNT_W-1:0]    ins_pos;
	logic [CNT_W-1:0]    rm_pos;
	logic                ins_ok;
	logic                rm_ok;
	status_t             op_status;
	logic [CNT_W-1:0]    op_index;
	logic [CNT_W-1:0]    count_nxt;

	assign ins_pos = at_end_s1 ? count_q : pos_s1;
	assign rm_pos  = at_end_s1 ? (count_q - CNT_W'(1)) : pos_s1;

	always_comb begin
		ins_ok    = 1'b0;
		rm_ok     = 1'b0;
		op_status = ST_INVALID;
		op_index  = '0;
		unique case (cmd_s1)
			CMD_INSERT: begin
				// bad position wins over full
				if (ins_pos > count_q) begin
					op_status = ST_INVALID;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					op_status = ST_FULL;
				end else begin
					op_status = ST_OK;
					op_index  = ins_pos;
					ins_ok    = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (count_q == '0 || rm_pos >= count_q) begin
					op_status = ST_INVALID;
				end else begin
					op_status = ST_OK;
					rm_ok     = 1'b1;
				end
			end
			CMD_SEARCH: begin
				// final status comes from the match encoder
				op_status = ST_NOT_FOUND;
			end
			default: begin
				op_status = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (valid_s1 && ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (valid_s1 && rm_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// cell chain: insert shifts toward the tail, remove toward the head
	ple_cell_ctl_t       cell_ctl [CAPACITY];
	logic [VALUE_W-1:0]  cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	logic [CAPACITY-1:0] occupied;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_in;
		logic [VALUE_W-1:0] right_in;

		always_comb begin
			cell_ctl[i].value = value_s1;
			cell_ctl[i].sel   = SEL_HOLD;
			if (valid_s1 && ins_ok) begin
				if (CNT_W'(i) == ins_pos) begin
					cell_ctl[i].sel = SEL_LOAD;
				end else if (CNT_W'(i) > ins_pos) begin
					cell_ctl[i].sel = SEL_LEFT;
				end
			end else if (valid_s1 && rm_ok) begin
				if (CNT_W'(i) >= rm_pos) begin
					cell_ctl[i].sel = SEL_RIGHT;
				end
			end
		end

		// the head never takes from the left, the tail refills with itself
		if (i == 0) begin : g_head
			assign left_in = value_s1;
		end else begin : g_body_l
			assign left_in = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_in = cell_data[i];
		end else begin : g_body_r
			assign right_in = cell_data[i+1];
		end

		assign occupied[i] = CNT_W'(i) < count_q;

		ple_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	// first match from the head, only among held entries
	logic               found;
	logic [CNT_W-1:0]   found_idx;

	ple_prio u_prio (
		.req   (match_s2),
		.found (found),
		.idx   (found_idx)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= op_status;
			index_s2  <= op_index;
			search_s2 <= (cmd_s1 == CMD_SEARCH);
			match_s2  <= cell_match & occupied;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			count_out_q <= count_q;
			if (search_s2) begin
				status_q <= found ? ST_OK : ST_NOT_FOUND;
				index_q  <= found ? found_idx : '0;
			end else begin
				status_q <= status_s2;
				index_q  <= index_s2;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			count_q <= count_nxt;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = status_q;
	assign result_index = index_q;
	assign entry_count  = count_out_q;

	// the two work stages never hold a request at the same time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("request stage and encode stage both occupied");

	// the count moves only in the cycle after a request was registered
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(valid_s1))
		else $error("entry count changed without a request");

	// the list never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// an accepted request blocks the next one for the following cycle
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("request accepted while another is in flight");

endmodule
